@@ design/rusi_pkg.sv @@
// ----------------------------------------------------------------------------
// rusi_pkg
// Shared types and constants for the unit cube slab intersection pipeline.
// ----------------------------------------------------------------------------
package rusi_pkg;

	// number format: signed fixed point
	localparam int VAL_W  = 32;
	localparam int FRAC_W = 16;

	// numerator c - o is held exactly, with headroom for the constant 1
	localparam int NUM_W = ((VAL_W > FRAC_W + 1) ? VAL_W : FRAC_W + 1) + 2;
	localparam int MAG_W = NUM_W - 1;

	// one divider stage for every bit of (magnitude << FRAC_W)
	localparam int DIV_N = MAG_W + FRAC_W;

	// parallel threshold register
	localparam int              EPS_W   = 16;
	localparam logic [EPS_W-1:0] EPS_RST = EPS_W'(7);

	// pipeline depth: input stage, divider, side, sort, min/max, output
	localparam int PIPE_N = DIV_N + 5;

	typedef logic signed [VAL_W-1:0] val_t;

	localparam val_t MAX_POS = {1'b0, {(VAL_W-1){1'b1}}};
	localparam val_t MAX_NEG = {1'b1, {(VAL_W-1){1'b0}}};

	typedef struct packed {
		val_t origin_x;
		val_t origin_y;
		val_t origin_z;
		val_t dir_x;
		val_t dir_y;
		val_t dir_z;
	} ray_t;

	typedef struct packed {
		logic hit;
		val_t t_enter;
		val_t t_exit;
	} res_t;

	// per-axis prepared operands
	typedef struct packed {
		logic [MAG_W-1:0] mag0;
		logic             neg0;
		logic [MAG_W-1:0] mag1;
		logic             neg1;
		logic [VAL_W-1:0] dmag;
		logic             dneg;
		logic             par;
	} axis_t;

	// flags that ride along with each quotient
	typedef struct packed {
		logic par;
		logic nneg;
		logic dneg;
		logic zero;
	} tag_t;

endpackage

@@ design/rusi_prep.sv @@
// ----------------------------------------------------------------------------
// rusi_prep
// Per-axis operand prep: exact numerators for both slab planes, direction
// magnitude and the parallel test.
// ----------------------------------------------------------------------------
module rusi_prep (
	input  rusi_pkg::val_t              o,
	input  rusi_pkg::val_t              d,
	input  logic [rusi_pkg::EPS_W-1:0]  eps,
	output rusi_pkg::axis_t             ax
);
	import rusi_pkg::*;

	localparam logic signed [NUM_W-1:0] ONE = NUM_W'(1) << FRAC_W;

	logic signed [NUM_W-1:0] ow;
	logic signed [NUM_W-1:0] n0;
	logic signed [NUM_W-1:0] n1;
	logic signed [NUM_W-1:0] n0_neg;
	logic signed [NUM_W-1:0] n1_neg;
	logic        [VAL_W-1:0] dm;

	// numerators -1 - o and 1 - o, no wrap
	always_comb begin
		ow     = {{(NUM_W-VAL_W){o[VAL_W-1]}}, o};
		n0     = -ONE - ow;
		n1     = ONE - ow;
		n0_neg = -n0;
		n1_neg = -n1;
	end

	// direction magnitude; the most negative code maps to 2^(W-1)
	assign dm = d[VAL_W-1] ? VAL_W'(-d) : d;

	always_comb begin
		ax.neg0 = n0[NUM_W-1];
		ax.mag0 = n0[NUM_W-1] ? n0_neg[MAG_W-1:0] : n0[MAG_W-1:0];
		ax.neg1 = n1[NUM_W-1];
		ax.mag1 = n1[NUM_W-1] ? n1_neg[MAG_W-1:0] : n1[MAG_W-1:0];
		ax.dmag = dm;
		ax.dneg = d[VAL_W-1];
		ax.par  = {{EPS_W{1'b0}}, dm} <= {{VAL_W{1'b0}}, eps};
	end

endmodule

@@ design/rusi_div.sv @@
// ----------------------------------------------------------------------------
// rusi_div
// Pipelined restoring divider, one quotient bit per stage. Computes
// (num << FRAC_W) / den truncated; quotient bits at or above VAL_W-1 only
// raise the saturation flag.
// ----------------------------------------------------------------------------
module rusi_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [rusi_pkg::MAG_W-1:0]  num,
	input  logic [rusi_pkg::VAL_W-1:0]  den,
	input  rusi_pkg::tag_t              tag_in,
	output logic [rusi_pkg::VAL_W-2:0]  quo,
	output logic                        sat,
	output rusi_pkg::tag_t              tag_out
);
	import rusi_pkg::*;

	logic [VAL_W-1:0] rem_s [DIV_N];
	logic [VAL_W-2:0] quo_s [DIV_N];
	logic             sat_s [DIV_N];
	logic [MAG_W-1:0] num_s [DIV_N];
	logic [VAL_W-1:0] den_s [DIV_N];
	tag_t             tag_s [DIV_N];

	for (genvar k = 0; k < DIV_N; k++) begin : g_stage
		localparam int POS = DIV_N - 1 - k;

		logic [VAL_W-1:0] rem_p;
		logic [VAL_W-2:0] quo_p;
		logic             sat_p;
		logic [MAG_W-1:0] num_p;
		logic [VAL_W-1:0] den_p;
		tag_t             tag_p;
		logic             nbit;
		logic [VAL_W:0]   sh;
		logic [VAL_W+1:0] diff;
		logic             qb;
		logic [VAL_W-1:0] rem_n;
		logic [VAL_W-2:0] quo_n;
		logic             sat_n;

		// previous stage, or the inputs for the first one
		if (k == 0) begin : g_first
			assign rem_p = '0;
			assign quo_p = '0;
			assign sat_p = 1'b0;
			assign num_p = num;
			assign den_p = den;
			assign tag_p = tag_in;
		end else begin : g_next
			assign rem_p = rem_s[k-1];
			assign quo_p = quo_s[k-1];
			assign sat_p = sat_s[k-1];
			assign num_p = num_s[k-1];
			assign den_p = den_s[k-1];
			assign tag_p = tag_s[k-1];
		end

		// next dividend bit; the fraction shift brings in zeros
		if (POS >= FRAC_W) begin : g_bit
			assign nbit = num_p[POS-FRAC_W];
		end else begin : g_zero
			assign nbit = 1'b0;
		end

		// trial subtract
		always_comb begin
			sh    = {rem_p, nbit};
			diff  = {1'b0, sh} - {2'b0, den_p};
			qb    = !diff[VAL_W+1];
			rem_n = qb ? diff[VAL_W-1:0] : sh[VAL_W-1:0];
		end

		if (POS <= VAL_W - 2) begin : g_qbit
			always_comb begin
				quo_n      = quo_p;
				quo_n[POS] = qb;
				sat_n      = sat_p;
			end
		end else begin : g_ovf
			always_comb begin
				quo_n = quo_p;
				sat_n = sat_p | qb;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= rem_n;
				quo_s[k] <= quo_n;
				sat_s[k] <= sat_n;
				num_s[k] <= num_p;
				den_s[k] <= den_p;
				tag_s[k] <= tag_p;
			end
		end
	end

	assign quo     = quo_s[DIV_N-1];
	assign sat     = sat_s[DIV_N-1];
	assign tag_out = tag_s[DIV_N-1];

endmodule

@@ design/ray_unit_cube_slab_intersect.sv @@
// ----------------------------------------------------------------------------
// ray_unit_cube_slab_intersect
// Ray against the cube [-1,1]^3 by the slab method, fully pipelined.
//
//   channel  dir  handshake               payload
//   ray      in   ray_valid / ray_stall   ray_t  origin xyz, direction xyz
//   res      out  res_valid / res_stall   res_t  hit, t_enter, t_exit
//   cfg      in   cfg_wr_en               cfg_wr_data  parallel epsilon
//
// One ray per cycle unless a stalled result holds the pipe; values are Q16.16. The
// pipe is the bit-per-stage divider (DIV_N = 49 stages) plus input, side select, sort,
// min/max and output stages. Reset clears the valid bits and loads epsilon
// with 7. A stalled result freezes the whole pipe; ray_stall follows it.
// ----------------------------------------------------------------------------
module ray_unit_cube_slab_intersect (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       ray_valid,
	output logic                       ray_stall,
	input  rusi_pkg::ray_t             ray,
	output logic                       res_valid,
	input  logic                       res_stall,
	output rusi_pkg::res_t             res,
	input  logic                       cfg_wr_en,
	input  logic [rusi_pkg::EPS_W-1:0] cfg_wr_data
);
	import rusi_pkg::*;

	logic             adv;
	logic [EPS_W-1:0] eps_q;
	logic [PIPE_N-1:0] vld_q;

	axis_t ax_c  [3];
	axis_t ax_s1 [3];

	logic [VAL_W-2:0] quo [6];
	logic             sat [6];
	tag_t             tag [6];

	val_t side_c  [6];
	val_t side_s2 [6];
	val_t lo_s3   [3];
	val_t hi_s3   [3];
	val_t ent_c;
	val_t ext_c;
	val_t ent_s4;
	val_t ext_s4;
	res_t res_s5;

	// whole pipe moves unless the output transfer is blocked
	assign adv       = !(vld_q[PIPE_N-1] && res_stall);
	assign ray_stall = !adv;

	// epsilon register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RST;
		end else if (cfg_wr_en) begin
			eps_q <= cfg_wr_data;
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PIPE_N-2:0], ray_valid};
		end
	end

	// stage 1: operand prep
	rusi_prep u_prep_x (.o(ray.origin_x), .d(ray.dir_x), .eps(eps_q), .ax(ax_c[0]));
	rusi_prep u_prep_y (.o(ray.origin_y), .d(ray.dir_y), .eps(eps_q), .ax(ax_c[1]));
	rusi_prep u_prep_z (.o(ray.origin_z), .d(ray.dir_z), .eps(eps_q), .ax(ax_c[2]));

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1 <= ax_c;
		end
	end

	// divider lanes: even lane is the -1 plane, odd lane the +1 plane
	for (genvar a = 0; a < 3; a++) begin : g_axis
		tag_t t0;
		tag_t t1;

		assign t0 = '{par: ax_s1[a].par, nneg: ax_s1[a].neg0, dneg: ax_s1[a].dneg,
			zero: (ax_s1[a].mag0 == '0)};
		assign t1 = '{par: ax_s1[a].par, nneg: ax_s1[a].neg1, dneg: ax_s1[a].dneg,
			zero: (ax_s1[a].mag1 == '0)};

		rusi_div u_div_lo (
			.clk(clk), .en(adv), .num(ax_s1[a].mag0), .den(ax_s1[a].dmag),
			.tag_in(t0), .quo(quo[2*a]), .sat(sat[2*a]), .tag_out(tag[2*a])
		);
		rusi_div u_div_hi (
			.clk(clk), .en(adv), .num(ax_s1[a].mag1), .den(ax_s1[a].dmag),
			.tag_in(t1), .quo(quo[2*a+1]), .sat(sat[2*a+1]), .tag_out(tag[2*a+1])
		);
	end

	// side values: parallel cases, zero numerator, saturation, sign
	for (genvar j = 0; j < 6; j++) begin : g_side
		logic sgn;
		val_t qv;

		assign sgn = tag[j].nneg ^ tag[j].dneg;
		assign qv  = {1'b0, quo[j]};

		always_comb begin
			if (tag[j].par) begin
				if (tag[j].zero) begin
					side_c[j] = ((j % 2) == 0) ? MAX_NEG : MAX_POS;
				end else begin
					side_c[j] = tag[j].nneg ? MAX_NEG : MAX_POS;
				end
			end else if (tag[j].zero) begin
				side_c[j] = '0;
			end else if (sat[j]) begin
				side_c[j] = sgn ? MAX_NEG : MAX_POS;
			end else begin
				side_c[j] = sgn ? -qv : qv;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_c;
		end
	end

	// order each axis pair
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				if (side_s2[2*a] > side_s2[2*a+1]) begin
					lo_s3[a] <= side_s2[2*a+1];
					hi_s3[a] <= side_s2[2*a];
				end else begin
					lo_s3[a] <= side_s2[2*a];
					hi_s3[a] <= side_s2[2*a+1];
				end
			end
		end
	end

	// entry is the largest low, exit the smallest high
	always_comb begin
		ent_c = lo_s3[0];
		if (lo_s3[1] > ent_c) ent_c = lo_s3[1];
		if (lo_s3[2] > ent_c) ent_c = lo_s3[2];
		ext_c = hi_s3[0];
		if (ext_c > hi_s3[1]) ext_c = hi_s3[1];
		if (ext_c > hi_s3[2]) ext_c = hi_s3[2];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ent_s4 <= ent_c;
			ext_s4 <= ext_c;
		end
	end

	// output register: hit test, miss reports zeros
	always_ff @(posedge clk) begin
		if (adv) begin
			if (ent_s4 > ext_s4) begin
				res_s5 <= '0;
			end else begin
				res_s5 <= '{hit: 1'b1, t_enter: ent_s4, t_exit: ext_s4};
			end
		end
	end

	assign res_valid = vld_q[PIPE_N-1];
	assign res       = res_s5;

endmodule

@@ design/rusi_chk.sv @@
// ----------------------------------------------------------------------------
// rusi_chk
// Port-level checks for the slab intersection block, bound to the top level.
// ----------------------------------------------------------------------------
module rusi_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           ray_stall,
	input logic           res_valid,
	input logic           res_stall,
	input rusi_pkg::res_t res
);
	import rusi_pkg::*;

	// blocked result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// input only stalls behind a blocked result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		ray_stall |-> res_valid && res_stall)
		else $error("input stalled without output back-pressure");

	// a miss carries zero distances
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.hit |-> res.t_enter == '0 && res.t_exit == '0)
		else $error("miss with nonzero distances");

	// a hit is an ordered interval
	a_hit_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.hit |-> res.t_enter <= res.t_exit)
		else $error("hit with entry past exit");

endmodule

bind ray_unit_cube_slab_intersect rusi_chk u_rusi_chk (
	.clk(clk),
	.arst_n(arst_n),
	.ray_stall(ray_stall),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res(res)
);
